// ===== rtl/spi_adc_slave_command_framer_core_defines.svh =====
// ----------------------------------------------------------------------------
// SPI ADC command framer: assertion macros
// Shared concurrent-assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SPI_ADC_SLAVE_COMMAND_FRAMER_CORE_DEFINES_SVH
`define SPI_ADC_SLAVE_COMMAND_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SACF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sacf: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SACF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sacf: assertion failed");

`endif

// ===== rtl/sacf_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI ADC command framer package
// Widths and the per-bit control bundle shared by the framer modules.
// ----------------------------------------------------------------------------
package sacf_pkg;

  localparam int WORD_W = 16;            // data and conversion word width
  localparam int CNT_W  = 4;             // bits_minus_one width
  localparam logic [WORD_W-1:0] CONV_RESET = 16'hFFFF;

  // One bit step handed to the protocol engine.
  typedef struct packed {
    logic step;    // handle one bit this cycle
    logic rx_bit;  // received bit
  } sacf_bit_ctrl_t;

endpackage

// ===== rtl/sacf_bit_engine.sv =====
// ----------------------------------------------------------------------------
// SPI ADC command framer: bit engine
// Output shift register, start-bit command counter and pending conversion.
// ----------------------------------------------------------------------------
module sacf_bit_engine
  import sacf_pkg::*;
#(
  parameter int COMMAND_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  input  sacf_bit_ctrl_t    ctrl,
  output logic              tx_bit
);

  localparam int CMD_CNT_W = $clog2(COMMAND_BITS);
  localparam logic [CMD_CNT_W-1:0] CMD_LAST  = CMD_CNT_W'(COMMAND_BITS - 1);
  localparam logic [CMD_CNT_W-1:0] CMD_FIRST = CMD_CNT_W'(1);

  logic [WORD_W-1:0]    conv_r,     conv_nxt;
  logic [WORD_W-1:0]    oshift_r,   oshift_nxt;
  logic [WORD_W-1:0]    pend_val_r, pend_val_nxt;
  logic                 pend_r,     pend_nxt;
  logic [CMD_CNT_W-1:0] cmd_cnt_r,  cmd_cnt_nxt;

  assign tx_bit = oshift_r[WORD_W-1];

  always_comb begin
    conv_nxt     = cfg_wr_en ? cfg_wr_data : conv_r;
    oshift_nxt   = oshift_r;
    pend_val_nxt = pend_val_r;
    pend_nxt     = pend_r;
    cmd_cnt_nxt  = cmd_cnt_r;
    if (ctrl.step) begin
      oshift_nxt = {oshift_r[WORD_W-2:0], 1'b0};
      if (cmd_cnt_r == '0) begin
        // idle: a one opens a command, pending value drops in
        if (ctrl.rx_bit) begin
          cmd_cnt_nxt = CMD_FIRST;
        end
        if (pend_r) begin
          pend_nxt   = 1'b0;
          oshift_nxt = pend_val_r;
        end
      end else if (cmd_cnt_r == CMD_LAST) begin
        cmd_cnt_nxt  = '0;
        pend_val_nxt = conv_r;
        pend_nxt     = 1'b1;
      end else begin
        cmd_cnt_nxt = cmd_cnt_r + CMD_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r     <= CONV_RESET;
      oshift_r   <= '0;
      pend_val_r <= '0;
      pend_r     <= 1'b0;
      cmd_cnt_r  <= '0;
    end else begin
      conv_r     <= conv_nxt;
      oshift_r   <= oshift_nxt;
      pend_val_r <= pend_val_nxt;
      pend_r     <= pend_nxt;
      cmd_cnt_r  <= cmd_cnt_nxt;
    end
  end

endmodule

// ===== rtl/spi_adc_slave_command_framer_core.sv =====
// ----------------------------------------------------------------------------
// SPI ADC slave command framer core
// Bit-serial model of an SPI ADC slave that frames start-bit commands.
// ----------------------------------------------------------------------------
// Each input item is one SPI exchange of bits_minus_one+1 bits (1 to 16),
// taken MSB first from data_in. The core walks the exchange one bit per
// clock while not stalled: per bit it shifts one bit out of a 16-bit
// output register and feeds the received bit to the command framer. An
// item is first loaded, then its bits are handled in turn; the last bit
// waits only if the previous result is still held by out_stall. The
// result is presented in an output register, so a new item can
// be accepted while the result waits. Outside a
// command, zero bits are dropped and a one opens a COMMAND_BITS-bit
// command; the last command bit arms cfg_wr_data's stored value
// (conversion_result, reset 0xFFFF) to be loaded on the next idle bit.
// Write cfg only while the core is idle.
// ----------------------------------------------------------------------------
module spi_adc_slave_command_framer_core
  import sacf_pkg::*;
#(
  parameter int COMMAND_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  // exchange in
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CNT_W-1:0]  in_bits_minus_one,
  input  logic [WORD_W-1:0] in_data_in,
  // bits out
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_data_out
);

  logic              busy_r,  busy_nxt;
  logic [CNT_W-1:0]  bit_r,   bit_nxt;     // index of the next bit to handle
  logic [WORD_W-1:0] data_r,  data_nxt;
  logic [WORD_W-1:0] res_r,   res_nxt;
  logic              oval_r,  oval_nxt;
  logic [WORD_W-1:0] odata_r, odata_nxt;

  logic           accept;
  logic           last_bit;
  logic           step;
  logic           tx_bit;
  sacf_bit_ctrl_t ctrl;

  assign in_stall     = busy_r;
  assign out_valid    = oval_r;
  assign out_data_out = odata_r;

  assign accept   = in_valid && !busy_r;
  assign last_bit = (bit_r == '0);
  // hold the final bit until the output register is free
  assign step     = busy_r && !(last_bit && oval_r && out_stall);

  assign ctrl = '{step: step, rx_bit: data_r[bit_r]};

  sacf_bit_engine #(
    .COMMAND_BITS (COMMAND_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctrl        (ctrl),
    .tx_bit      (tx_bit)
  );

  always_comb begin
    busy_nxt  = busy_r;
    bit_nxt   = bit_r;
    data_nxt  = data_r;
    res_nxt   = res_r;
    oval_nxt  = oval_r && out_stall;
    odata_nxt = odata_r;
    if (accept) begin
      busy_nxt = 1'b1;
      bit_nxt  = in_bits_minus_one;
      data_nxt = in_data_in;
      res_nxt  = '0;
    end else if (step) begin
      // collect shifted-out bits, right aligned
      res_nxt = {res_r[WORD_W-2:0], tx_bit};
      if (last_bit) begin
        busy_nxt  = 1'b0;
        oval_nxt  = 1'b1;
        odata_nxt = {res_r[WORD_W-2:0], tx_bit};
      end else begin
        bit_nxt = bit_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r   <= bit_nxt;
    data_r  <= data_nxt;
    res_r   <= res_nxt;
    odata_r <= odata_nxt;
  end

endmodule

// ===== rtl/sacf_checker.sv =====
// ----------------------------------------------------------------------------
// SPI ADC command framer: port checker
// Watches the core's ports and is bound to every core instance.
// ----------------------------------------------------------------------------
`include "spi_adc_slave_command_framer_core_defines.svh"

module sacf_checker
  import sacf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] out_data_out
);

  // a held result stays put
  `SACF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data_out))
  // an accepted item keeps the input closed while it runs
  `SACF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // no result shows up in the cycle right after an accept
  `SACF_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && !out_valid, !out_valid)
  // finishing an item always leaves a result behind
  `SACF_ASSERT_NOW(a_done_has_result, $past(rst_n) && $fell(in_stall), out_valid)

endmodule

bind spi_adc_slave_command_framer_core sacf_checker u_sacf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_data_out (out_data_out)
);
